[rtl/pba_pkg.sv]
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, codes and the control store of the page bitmap allocator.
// ----------------------------------------------------------------------------
package pba_pkg;

  // default sizes of the page store
  localparam int NUM_PAGES_DEF = 65536;
  localparam int WORD_BITS_DEF = 32;

  // field widths of the stream items and the register
  localparam int FUNC_W      = 3;
  localparam int PAGE_W      = 16;
  localparam int END_W       = 17;
  localparam int CFG_W       = 17;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 24;
  localparam int INDEX_LIMIT = 65536;

  // request codes
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FN_ALLOC      = 3'd0;
  localparam func_t FN_FREE       = 3'd1;
  localparam func_t FN_RANGE_FREE = 3'd2;
  localparam func_t FN_RANGE_USED = 3'd3;
  localparam func_t FN_TEST       = 3'd4;

  // datapath operations selected by the control word
  typedef enum logic [2:0] {
    DP_NOP,
    DP_CLEAR,
    DP_SET_ALLOC,
    DP_SCAN,
    DP_SET_RANGE,
    DP_UPDATE,
    DP_SET_TEST,
    DP_TEST
  } dp_op_t;

  // jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_EMPTY,
    C_SCAN_DONE,
    C_LAST,
    C_WORD_END,
    C_OUT_FREE
  } cond_t;

  // microprogram step addresses
  typedef logic [3:0] step_t;
  localparam step_t ST_CLEAR   = 4'd0;
  localparam step_t ST_IDLE    = 4'd1;
  localparam step_t ST_AL_SET  = 4'd2;
  localparam step_t ST_AL_SCAN = 4'd3;
  localparam step_t ST_RG_SET  = 4'd4;
  localparam step_t ST_RG_UPD  = 4'd5;
  localparam step_t ST_TS_SET  = 4'd6;
  localparam step_t ST_TS_BIT  = 4'd7;
  localparam step_t ST_EMIT    = 4'd8;

  // one control word
  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  t_true;
    step_t  t_false;
    logic   take;
    logic   emit;
  } ctl_t;

  // datapath flags seen by the sequencer
  typedef struct packed {
    logic empty;
    logic last;
    logic hit;
    logic word_end;
  } dp_stat_t;

  // control store
  function automatic ctl_t ucode(input step_t s);
    ctl_t c;
    c = '{op: DP_NOP, cond: C_ALWAYS, t_true: ST_IDLE, t_false: ST_IDLE,
          take: 1'b0, emit: 1'b0};
    case (s)
      ST_CLEAR: begin
        c = '{op: DP_CLEAR, cond: C_WORD_END, t_true: ST_IDLE, t_false: ST_CLEAR,
              take: 1'b0, emit: 1'b0};
      end
      ST_IDLE: begin
        c = '{op: DP_NOP, cond: C_ACCEPT, t_true: ST_IDLE, t_false: ST_IDLE,
              take: 1'b1, emit: 1'b0};
      end
      ST_AL_SET: begin
        c = '{op: DP_SET_ALLOC, cond: C_EMPTY, t_true: ST_EMIT, t_false: ST_AL_SCAN,
              take: 1'b0, emit: 1'b0};
      end
      ST_AL_SCAN: begin
        c = '{op: DP_SCAN, cond: C_SCAN_DONE, t_true: ST_EMIT, t_false: ST_AL_SCAN,
              take: 1'b0, emit: 1'b0};
      end
      ST_RG_SET: begin
        c = '{op: DP_SET_RANGE, cond: C_EMPTY, t_true: ST_EMIT, t_false: ST_RG_UPD,
              take: 1'b0, emit: 1'b0};
      end
      ST_RG_UPD: begin
        c = '{op: DP_UPDATE, cond: C_LAST, t_true: ST_EMIT, t_false: ST_RG_UPD,
              take: 1'b0, emit: 1'b0};
      end
      ST_TS_SET: begin
        c = '{op: DP_SET_TEST, cond: C_EMPTY, t_true: ST_EMIT, t_false: ST_TS_BIT,
              take: 1'b0, emit: 1'b0};
      end
      ST_TS_BIT: begin
        c = '{op: DP_TEST, cond: C_ALWAYS, t_true: ST_EMIT, t_false: ST_EMIT,
              take: 1'b0, emit: 1'b0};
      end
      ST_EMIT: begin
        c = '{op: DP_NOP, cond: C_OUT_FREE, t_true: ST_IDLE, t_false: ST_EMIT,
              take: 1'b0, emit: 1'b1};
      end
      default: begin
        c = '{op: DP_NOP, cond: C_ALWAYS, t_true: ST_IDLE, t_false: ST_IDLE,
              take: 1'b0, emit: 1'b0};
      end
    endcase
    return c;
  endfunction

  // entry step for each request code
  function automatic step_t dispatch(input func_t f);
    step_t s;
    case (f)
      FN_ALLOC:      s = ST_AL_SET;
      FN_FREE:       s = ST_RG_SET;
      FN_RANGE_FREE: s = ST_RG_SET;
      FN_RANGE_USED: s = ST_RG_SET;
      FN_TEST:       s = ST_TS_SET;
      default:       s = ST_EMIT;
    endcase
    return s;
  endfunction

endpackage

[rtl/pba_sequencer.sv]
// ----------------------------------------------------------------------------
// pba_sequencer
// Step counter and control store lookup with conditional jumps.
// ----------------------------------------------------------------------------
module pba_sequencer import pba_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  func_t    in_func,
  input  logic     out_free,
  input  dp_stat_t stat,
  output ctl_t     ctl
);

  step_t upc_r;
  step_t upc_nxt;
  logic  cond_ok;

  // current control word
  assign ctl = ucode(upc_r);

  // condition select
  always_comb begin
    case (ctl.cond)
      C_ALWAYS:    cond_ok = 1'b1;
      C_ACCEPT:    cond_ok = in_valid;
      C_EMPTY:     cond_ok = stat.empty;
      C_SCAN_DONE: cond_ok = stat.hit | stat.last;
      C_LAST:      cond_ok = stat.last;
      C_WORD_END:  cond_ok = stat.word_end;
      C_OUT_FREE:  cond_ok = out_free;
      default:     cond_ok = 1'b1;
    endcase
  end

  // next step, the accept jump goes through the dispatch table
  always_comb begin
    if (cond_ok) begin
      upc_nxt = (ctl.cond == C_ACCEPT) ? dispatch(in_func) : ctl.t_true;
    end else begin
      upc_nxt = ctl.t_false;
    end
  end

  // step counter, starts with the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= ST_CLEAR;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

[rtl/pba_datapath.sv]
// ----------------------------------------------------------------------------
// pba_datapath
// Bitmap memory, word walker, range mask, free bit search and result regs.
// ----------------------------------------------------------------------------
module pba_datapath import pba_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ctl_t              ctl,
  input  logic              in_acc,
  input  func_t             in_func,
  input  logic [PAGE_W-1:0] in_first,
  input  logic [END_W-1:0]  in_end,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output dp_stat_t          stat,
  output logic [PAGE_W-1:0] res_index,
  output logic              res_status,
  output logic              res_used
);

  // WORD_BITS is a power of two
  localparam int SW      = NUM_PAGES / WORD_BITS;
  localparam int SP      = SW * WORD_BITS;
  localparam int WB      = $clog2(WORD_BITS);
  localparam int AW      = (SW > 1) ? $clog2(SW) : 1;
  localparam int CW      = ($clog2(SP + 1) > END_W) ? $clog2(SP + 1) : END_W;
  localparam int LIM_CAP = (SP < INDEX_LIMIT) ? SP : INDEX_LIMIT;

  logic [WORD_BITS-1:0] mem [SW];
  logic [WORD_BITS-1:0] rdata_r;

  logic [CFG_W-1:0]     managed_r;
  func_t                func_r;
  logic [PAGE_W-1:0]    first_r;
  logic [END_W-1:0]     end_r;
  logic [AW-1:0]        w_r;
  logic [AW-1:0]        first_w_r;
  logic [AW-1:0]        last_w_r;
  logic [WB-1:0]        lo_bit_r;
  logic [WB-1:0]        hi_bit_r;
  logic [PAGE_W-1:0]    idx_r;
  logic                 status_r;
  logic                 used_r;

  logic [CW-1:0]        first_c;
  logic [CW-1:0]        end_req;
  logic [CW-1:0]        end_c;
  logic [CW-1:0]        lim_req;
  logic [CW-1:0]        lim_c;
  logic [CW-1:0]        last_pg;
  logic [CW-1:0]        first_sh;
  logic [CW-1:0]        last_sh;
  logic [CW-1:0]        page_full;
  logic                 empty;
  logic                 at_first;
  logic                 at_last;
  logic [WB-1:0]        lo;
  logic [WB-1:0]        hi;
  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free_bits;
  logic [WORD_BITS-1:0] pick;
  logic [WB-1:0]        pos;
  logic                 hit;
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;
  logic                 mem_re;
  logic [AW-1:0]        mem_raddr;

  // clipped bounds of the request
  always_comb begin
    first_c = CW'(first_r);
    end_req = (func_r == FN_FREE) ? CW'(first_r) + CW'(1) : CW'(end_r);
    end_c   = (end_req > CW'(SP)) ? CW'(SP) : end_req;
    lim_req = CW'(managed_r);
    lim_c   = (lim_req > CW'(LIM_CAP)) ? CW'(LIM_CAP) : lim_req;
    last_pg = (ctl.op == DP_SET_ALLOC) ? lim_c - CW'(1) : end_c - CW'(1);
    first_sh = first_c >> WB;
    last_sh  = last_pg >> WB;
  end

  // nothing to walk for this request
  always_comb begin
    case (ctl.op)
      DP_SET_ALLOC: empty = (lim_c == '0);
      DP_SET_RANGE: empty = (first_c >= end_c);
      DP_SET_TEST:  empty = (first_c >= CW'(SP));
      default:      empty = 1'b0;
    endcase
  end

  // bit mask of the pages in range inside the current word
  always_comb begin
    at_first = (w_r == first_w_r);
    at_last  = (w_r == last_w_r);
    lo = at_first ? lo_bit_r : '0;
    hi = at_last ? hi_bit_r : WB'(WORD_BITS - 1);
    for (int b = 0; b < WORD_BITS; b++) begin
      mask[b] = (WB'(b) >= lo) && (WB'(b) <= hi);
    end
  end

  // lowest free page in the current word
  always_comb begin
    free_bits = ~rdata_r & mask;
    pos = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        pos = WB'(b);
      end
    end
    pick = '0;
    pick[pos] = 1'b1;
    hit = (ctl.op == DP_SCAN) && (|free_bits);
    page_full = CW'({w_r, pos});
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rdata_r;
    mem_re    = 1'b0;
    mem_raddr = w_r + AW'(1);
    case (ctl.op)
      DP_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '1;
      end
      DP_SET_ALLOC: begin
        mem_re    = ~empty;
        mem_raddr = '0;
      end
      DP_SET_RANGE, DP_SET_TEST: begin
        mem_re    = ~empty;
        mem_raddr = first_sh[AW-1:0];
      end
      DP_SCAN: begin
        mem_we    = hit;
        mem_wdata = rdata_r | pick;
        mem_re    = ~hit & ~at_last;
      end
      DP_UPDATE: begin
        mem_we    = 1'b1;
        mem_wdata = (func_r == FN_RANGE_USED) ? (rdata_r | mask) : (rdata_r & ~mask);
        mem_re    = ~at_last;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // bitmap memory, one write and one registered read a cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[w_r] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[mem_raddr];
    end
  end

  // request capture, walker and results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      managed_r <= '0;
      w_r       <= '0;
    end else begin
      if (cfg_we) begin
        managed_r <= cfg_wdata;
      end
      if (in_acc) begin
        func_r   <= in_func;
        first_r  <= in_first;
        end_r    <= in_end;
        idx_r    <= '0;
        status_r <= 1'b0;
        used_r   <= 1'b0;
      end
      case (ctl.op)
        DP_CLEAR: begin
          w_r <= w_r + AW'(1);
        end
        DP_SET_ALLOC: begin
          w_r       <= '0;
          first_w_r <= '0;
          last_w_r  <= last_sh[AW-1:0];
          lo_bit_r  <= '0;
          hi_bit_r  <= last_pg[WB-1:0];
          if (empty) begin
            status_r <= 1'b1;
          end
        end
        DP_SET_RANGE: begin
          w_r       <= first_sh[AW-1:0];
          first_w_r <= first_sh[AW-1:0];
          last_w_r  <= last_sh[AW-1:0];
          lo_bit_r  <= first_c[WB-1:0];
          hi_bit_r  <= last_pg[WB-1:0];
        end
        DP_SET_TEST: begin
          w_r      <= first_sh[AW-1:0];
          lo_bit_r <= first_c[WB-1:0];
          if (empty) begin
            used_r <= 1'b1;
          end
        end
        DP_SCAN: begin
          if (hit) begin
            idx_r <= page_full[PAGE_W-1:0];
          end else if (at_last) begin
            status_r <= 1'b1;
          end else begin
            w_r <= w_r + AW'(1);
          end
        end
        DP_UPDATE: begin
          if (!at_last) begin
            w_r <= w_r + AW'(1);
          end
        end
        DP_TEST: begin
          used_r <= rdata_r[lo_bit_r];
        end
        default: begin
          w_r <= w_r;
        end
      endcase
    end
  end

  assign stat.empty    = empty;
  assign stat.last     = at_last;
  assign stat.hit      = hit;
  assign stat.word_end = (w_r == AW'(SW - 1));

  assign res_index  = idx_r;
  assign res_status = status_r;
  assign res_used   = used_r;

endmodule

[rtl/page_bitmap_allocator_unit.sv]
// ----------------------------------------------------------------------------
// page_bitmap_allocator_unit
// Page frame allocator over a used-bit bitmap, run by a microprogram.
// ----------------------------------------------------------------------------
// channel  dir  tdata                               tuser
// in_      in   [15:0] first_page, [32:16] range_end [2:0] func
// out_     out  [15:0] page_index, [16] page_used   [0] status
// cfg_     in   cfg_wdata[16:0] managed_pages       -
//
// The memory port walks one bitmap word a cycle: alloc walks from word 0
// up to the first word with a free page, range ops walk the words of the
// range, free and test touch one word, unknown codes walk no word.
// After reset a clearing pass sets every page used; in_tready stays low
// meanwhile. A stalled result holds the block before it takes the next item.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_unit import pba_pkg::*; #(
  parameter int NUM_PAGES = NUM_PAGES_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // first_page, range_end, zero pad
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // page_index, page_used, zero pad
  output logic                  out_tuser,  // status
  // managed page count
  input  logic                  cfg_we,
  input  logic [CFG_W-1:0]      cfg_wdata
);

  ctl_t                  ctl;
  dp_stat_t              stat;
  logic                  in_acc;
  logic                  out_free;
  logic                  out_load;
  logic [PAGE_W-1:0]     res_index;
  logic                  res_status;
  logic                  res_used;
  logic                  out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;
  logic                  out_tuser_r;

  // handshake decode
  assign in_tready = ctl.take;
  assign in_acc    = in_tvalid & in_tready;
  assign out_free  = ~out_tvalid_r | out_tready;
  assign out_load  = ctl.emit & out_free;

  pba_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_func  (in_tuser),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl)
  );

  pba_datapath #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .in_acc     (in_acc),
    .in_func    (in_tuser),
    .in_first   (in_tdata[PAGE_W-1:0]),
    .in_end     (in_tdata[PAGE_W+END_W-1:PAGE_W]),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .stat       (stat),
    .res_index  (res_index),
    .res_status (res_status),
    .res_used   (res_used)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_tvalid_r <= 1'b1;
        out_tdata_r  <= {{(OUT_DATA_W-PAGE_W-1){1'b0}}, res_used, res_index};
        out_tuser_r  <= res_status;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

[rtl/pba_checker.sv]
// ----------------------------------------------------------------------------
// pba_checker
// Port level checks of the page bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pba_checker import pba_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic [FUNC_W-1:0]     in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tuser,
  input logic                  cfg_we,
  input logic [CFG_W-1:0]      cfg_wdata
);

  // a stalled result is not dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a failed alloc reports page zero
  a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[PAGE_W-1:0] == '0)
    else $error("failed alloc with nonzero page index");

  // a failed alloc never carries a used bit
  a_fail_used: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> !out_tdata[PAGE_W])
    else $error("failed alloc with page_used set");

  // no request taken right after reset is released, when the clearing pass begins
  a_clear_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !in_tready)
    else $error("request taken during clearing pass");

endmodule

bind page_bitmap_allocator_unit pba_checker u_pba_checker (.*);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the page bitmap allocator. Requests go in on the
// input stream with random gaps, and a bit-level copy of the page bitmap
// predicts every result. Results are drained with random stalls and compared
// field by field in order. Directed tests cover the reset map, the search
// limit, range clipping and unknown codes, then random page traffic follows.
// ----------------------------------------------------------------------------
module testbench import pba_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 6;
  localparam int MAX_GAP        = 17;
  localparam int STORE_PAGES    = NUM_PAGES_DEF;
  localparam int STORE_WORDS    = NUM_PAGES_DEF / WORD_BITS_DEF;
  localparam int PAGE_MAX       = (1 << PAGE_W) - 1;
  localparam int END_MAX        = (1 << END_W) - 1;
  localparam int FUNC_MAX       = (1 << FUNC_W) - 1;
  localparam int RESERVED_PAGES = 256;
  localparam int LIMIT_PAGES    = 300;
  localparam int CFG_SETTLE     = 4;
  localparam int LONG_HOLD      = 300;
  localparam int BURST_ITEMS    = 12;
  localparam int RANDOM_ITEMS   = 240;
  localparam int RANDOM_PHASES  = 6;
  localparam int CYCLE_LIMIT    = 3_000_000;

  // one result transfer
  typedef struct packed {
    logic [PAGE_W-1:0] page_index;
    logic              status;
    logic              page_used;
  } result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // first_page, range_end, zero pad
  logic [FUNC_W-1:0]     in_tuser;   // func
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // page_index, page_used, zero pad
  logic                  out_tuser;  // status
  logic                  cfg_we;
  logic [CFG_W-1:0]      cfg_wdata;

  // predicted page map and register copy
  bit               used_map [0:STORE_PAGES-1];
  logic [CFG_W-1:0] managed_cfg;
  result_t          pending_results [$];

  int err_count   = 0;
  int items_sent  = 0;
  int cycle_count = 0;
  bit snd_idle    = 1'b1;
  bit rcv_idle    = 1'b1;
  int rcv_hold    = 0;

  page_bitmap_allocator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // apply one request to the predicted map and return its result
  function automatic result_t apply_request(input func_t f, input logic [PAGE_W-1:0] first_pg,
                                            input logic [END_W-1:0] stop_pg);
    result_t r;
    int      lim;
    int      stop;
    int      i;
    r = '0;
    case (f)
      FN_ALLOC: begin
        lim = int'(managed_cfg);
        if (lim > STORE_PAGES) lim = STORE_PAGES;
        if (lim > INDEX_LIMIT) lim = INDEX_LIMIT;
        i = 0;
        while (i < lim && used_map[i]) i++;
        if (i < lim) begin
          used_map[i]  = 1'b1;
          r.page_index = i[PAGE_W-1:0];
        end else begin
          r.status = 1'b1;
        end
      end
      FN_FREE: begin
        if (first_pg < STORE_PAGES) used_map[first_pg] = 1'b0;
      end
      FN_RANGE_FREE, FN_RANGE_USED: begin
        stop = int'(stop_pg);
        if (stop > STORE_PAGES) stop = STORE_PAGES;
        for (i = int'(first_pg); i < stop; i++) used_map[i] = (f == FN_RANGE_USED);
      end
      FN_TEST: begin
        // pages beyond the store read as used
        r.page_used = (first_pg < STORE_PAGES) ? used_map[first_pg] : 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // offer one request, predict its result once the transfer happens
  task automatic send_req(input func_t f, input int first_pg, input int stop_pg,
                          output result_t got);
    int                gap;
    logic [PAGE_W-1:0] first_v;
    logic [END_W-1:0]  stop_v;
    first_v = PAGE_W'(first_pg);
    stop_v  = END_W'(stop_pg);
    gap = snd_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - PAGE_W - END_W){1'b0}}, stop_v, first_v};
    in_tuser  <= f;
    do @(posedge clk); while (!in_tready);
    got = apply_request(f, first_v, stop_v);
    pending_results.push_back(got);
    items_sent++;
  endtask

  // stop offering and wait for every predicted result
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // register write while the block is idle
  task automatic set_managed(input int pages);
    wait_drain();
    repeat (CFG_SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CFG_W'(pages);
    @(posedge clk);
    cfg_we      <= 1'b0;
    managed_cfg = CFG_W'(pages);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  // result sink: random stalls, one long hold when requested
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    forever begin
      if (rcv_hold > 0) begin
        stall    = rcv_hold;
        rcv_hold = 0;
      end else begin
        stall = rcv_idle ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual index %0d status %0d used %0d",
                 $time, out_tdata[PAGE_W-1:0], out_tuser, out_tdata[PAGE_W]);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("page_index", int'(want.page_index), int'(out_tdata[PAGE_W-1:0]));
        check_field("page_used", int'(want.page_used), int'(out_tdata[PAGE_W]));
        check_field("status", int'(want.status), int'(out_tuser));
        check_field("tdata pad", 0, int'(out_tdata[OUT_DATA_W-1:PAGE_W+1]));
      end
    end
  end

  // everything used after reset, empty and full search limits
  task automatic test_reset_state();
    result_t r;
    set_managed(0);
    send_req(FN_ALLOC, PAGE_MAX, END_MAX, r);
    send_req(FN_TEST, 0, 0, r);
    send_req(FN_TEST, PAGE_MAX, END_MAX, r);
    // register above the store size, scan of a fully used map
    set_managed(END_MAX);
    send_req(FN_ALLOC, 0, 0, r);
  endtask

  // allocate, free and test in the low pages
  task automatic test_alloc_free();
    result_t r;
    send_req(FN_RANGE_FREE, 0, 64, r);
    send_req(FN_ALLOC, 0, 0, r);
    send_req(FN_ALLOC, 0, 0, r);
    send_req(FN_FREE, 0, END_MAX, r);
    send_req(FN_TEST, 0, 0, r);
    send_req(FN_ALLOC, 0, 0, r);
  endtask

  // empty ranges, end clipped to the store, top page
  task automatic test_range_edges();
    result_t r;
    send_req(FN_RANGE_FREE, 100, 100, r);
    send_req(FN_RANGE_FREE, 200, 50, r);
    send_req(FN_RANGE_FREE, 65500, END_MAX, r);
    send_req(FN_TEST, PAGE_MAX, 0, r);
    send_req(FN_RANGE_USED, PAGE_MAX, STORE_PAGES, r);
    send_req(FN_TEST, PAGE_MAX, 0, r);
    send_req(FN_FREE, PAGE_MAX, 0, r);
  endtask

  // low reservation and a search limit inside the map
  task automatic test_search_limit();
    result_t r;
    set_managed(STORE_PAGES);
    send_req(FN_ALLOC, 0, 0, r);
    send_req(FN_RANGE_USED, 0, RESERVED_PAGES, r);
    set_managed(LIMIT_PAGES);
    send_req(FN_ALLOC, 0, 0, r);
    send_req(FN_RANGE_FREE, LIMIT_PAGES - 1, LIMIT_PAGES + 2, r);
    send_req(FN_ALLOC, 0, 0, r);
    send_req(FN_ALLOC, 0, 0, r);
  endtask

  // codes past test change nothing and return zeros
  task automatic test_unknown_func();
    result_t r;
    func_t   f;
    for (int k = FN_TEST + 1; k <= FUNC_MAX; k++) begin
      f = func_t'(k);
      send_req(f, PAGE_MAX, END_MAX, r);
    end
  endtask

  // long receiver hold with back-to-back requests fills the block
  task automatic test_backpressure();
    result_t r;
    snd_idle = 1'b0;
    rcv_hold = LONG_HOLD;
    repeat (BURST_ITEMS) begin
      send_req($urandom_range(0, 1) ? FN_TEST : FN_FREE, $urandom,
               $urandom_range(0, END_MAX), r);
    end
    wait_drain();
    snd_idle = 1'b1;
  endtask

  // phases of random traffic under different search limits
  task automatic test_random_traffic();
    result_t           r;
    func_t             f;
    int                phase_stop;
    int                base;
    int                len;
    int                first_pg;
    int                stop_pg;
    logic [PAGE_W-1:0] held [$];
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       set_managed(0);
        1:       set_managed(STORE_PAGES);
        2:       set_managed(END_MAX);
        3:       set_managed($urandom_range(1, 4096));
        default: set_managed($urandom_range(0, END_MAX));
      endcase
      snd_idle   = ($urandom_range(0, 3) != 0);
      rcv_idle   = ($urandom_range(0, 3) != 0);
      phase_stop = items_sent + RANDOM_ITEMS / RANDOM_PHASES;
      while (items_sent < phase_stop) begin
        if ($urandom_range(0, 9) < 6) begin
          // free a block, allocate from the map, test the pages and free some of them
          base = ($urandom_range(0, 3) == 0) ? $urandom_range(0, PAGE_MAX)
                                             : $urandom_range(0, 2047);
          len  = $urandom_range(1, 64);
          send_req(FN_RANGE_FREE, base, base + len, r);
          repeat ($urandom_range(1, 4)) begin
            send_req(FN_ALLOC, $urandom, $urandom_range(0, END_MAX), r);
            if (!r.status) held.push_back(r.page_index);
          end
          while (held.size() > 0) begin
            send_req(FN_TEST, int'(held[0]), $urandom_range(0, END_MAX), r);
            if ($urandom_range(0, 1))
              send_req(FN_FREE, int'(held[0]), $urandom_range(0, END_MAX), r);
            held.delete(0);
          end
          if ($urandom_range(0, 2) == 0)
            send_req(FN_RANGE_USED, base, base + $urandom_range(0, len), r);
        end else begin
          // single random request, ranges mostly short, some inverted
          f        = func_t'($urandom_range(0, FUNC_MAX));
          first_pg = $urandom_range(0, PAGE_MAX);
          if ((f == FN_RANGE_FREE || f == FN_RANGE_USED) && $urandom_range(0, 15) != 0) begin
            len     = $urandom_range(0, 160);
            stop_pg = first_pg + len - 32;
            if (stop_pg < 0) stop_pg = 0;
          end else begin
            stop_pg = $urandom_range(0, END_MAX);
          end
          send_req(f, first_pg, stop_pg, r);
        end
      end
    end
    snd_idle = 1'b1;
    rcv_idle = 1'b1;
  endtask

  // reset, tests in turn, final verdict
  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    cfg_we      = 1'b0;
    cfg_wdata   = '0;
    managed_cfg = '0;
    for (int p = 0; p < STORE_PAGES; p++) used_map[p] = 1'b1;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_alloc_free();
    test_range_edges();
    test_search_limit();
    test_unknown_func();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (STORE_WORDS + 8) @(posedge clk);
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
